// File: rtl/grsm_pkg.sv
// ----------------------------------------------------------------------------
// grsm_pkg
// shared types, verdict codes and rice parameter clamp for the set matcher
// ----------------------------------------------------------------------------
package grsm_pkg;

	localparam logic [1:0] VERDICT_MATCH     = 2'd0;
	localparam logic [1:0] VERDICT_PASSED    = 2'd1;
	localparam logic [1:0] VERDICT_EXHAUSTED = 2'd2;
	localparam logic [1:0] VERDICT_TRUNCATED = 2'd3;

	localparam logic [1:0] REG_TARGET_HASH   = 2'd0;
	localparam logic [1:0] REG_ELEMENT_COUNT = 2'd1;
	localparam logic [1:0] REG_RICE_BITS     = 2'd2;

	localparam logic [5:0] RICE_MIN   = 6'd7;
	localparam logic [5:0] RICE_MAX   = 6'd32;
	localparam logic [5:0] RICE_RESET = 6'd19;

	typedef struct packed {
		logic [63:0] target_hash;
		logic [31:0] element_count;
		logic [5:0]  rice_bits;
	} cfg_t;

	typedef struct packed {
		logic        in_rem;
		logic [5:0]  left;
		logic [31:0] acc;
	} walk_state_t;

	typedef struct packed {
		logic        done;
		logic [3:0]  ones_pre;
		logic [3:0]  ones_post;
		logic [31:0] acc_done;
		walk_state_t nxt;
	} walk_result_t;

	function automatic logic [5:0] rice_clamp(input logic [5:0] rb);
		logic [5:0] r;
		if (rb < RICE_MIN) begin
			r = RICE_MIN;
		end else if (rb > RICE_MAX) begin
			r = RICE_MAX;
		end else begin
			r = rb;
		end
		return r;
	endfunction

endpackage

// File: rtl/grsm_cfg_regs.sv
// ----------------------------------------------------------------------------
// grsm_cfg_regs
// configuration register file: target hash, element count, rice parameter
// ----------------------------------------------------------------------------
module grsm_cfg_regs (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [63:0]        cfg_data,
	output grsm_pkg::cfg_t     cfg
);
	import grsm_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.target_hash   <= '0;
			cfg_q.element_count <= '0;
			cfg_q.rice_bits     <= RICE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_TARGET_HASH:   cfg_q.target_hash   <= cfg_data;
				REG_ELEMENT_COUNT: cfg_q.element_count <= cfg_data[31:0];
				REG_RICE_BITS:     cfg_q.rice_bits     <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

endmodule

// File: rtl/grsm_bit_walk.sv
// ----------------------------------------------------------------------------
// grsm_bit_walk
// walks the eight bits of one coded byte, msb first, through the unary and
// remainder phases; reports at most one completed value per byte
// ----------------------------------------------------------------------------
module grsm_bit_walk (
	input  logic [7:0]                byte_in,
	input  logic [5:0]                rice_eff,
	input  grsm_pkg::walk_state_t     st,
	output grsm_pkg::walk_result_t    res
);
	import grsm_pkg::*;

	logic        in_rem_v;
	logic [5:0]  left_v;
	logic [31:0] acc_v;
	logic [31:0] acc_done_v;
	logic [3:0]  ones_pre_v;
	logic [3:0]  ones_post_v;
	logic        done_v;

	always_comb begin
		in_rem_v    = st.in_rem;
		left_v      = st.left;
		acc_v       = st.acc;
		acc_done_v  = '0;
		ones_pre_v  = '0;
		ones_post_v = '0;
		done_v      = 1'b0;
		for (int i = 7; i >= 0; i--) begin
			if (!in_rem_v) begin
				if (byte_in[i]) begin
					if (done_v) begin
						ones_post_v = ones_post_v + 4'd1;
					end else begin
						ones_pre_v = ones_pre_v + 4'd1;
					end
				end else begin
					in_rem_v = 1'b1;
					acc_v    = '0;
					left_v   = rice_eff;
				end
			end else begin
				acc_v  = {acc_v[30:0], byte_in[i]};
				left_v = left_v - 6'd1;
				if (left_v == 6'd0) begin
					done_v     = 1'b1;
					acc_done_v = acc_v;
					acc_v      = '0;
					in_rem_v   = 1'b0;
				end
			end
		end
		res.done       = done_v;
		res.ones_pre   = ones_pre_v;
		res.ones_post  = ones_post_v;
		res.acc_done   = acc_done_v;
		res.nxt.in_rem = in_rem_v;
		res.nxt.left   = left_v;
		res.nxt.acc    = acc_v;
	end

endmodule

// File: rtl/golomb_rice_set_membership_matcher_core.sv
// ----------------------------------------------------------------------------
// golomb_rice_set_membership_matcher_core
// a verdict word reaches the master side from the result register; its byte
// passes the input register first. throughput: one coded byte per cycle
// while no untaken verdict stalls the master side, set by the per-byte loop
// through the bit walk, 64-bit delta add and target compare back into scan state
// reset: config returns to target 0, count 0, rice 19; scan state clears
// ----------------------------------------------------------------------------
module golomb_rice_set_membership_matcher_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] byte_in
	input  logic        s_tuser,   // [0] first
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [1:0] verdict, [33:2] values_read, [39:34] zero
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data
);
	import grsm_pkg::*;

	cfg_t         cfg;
	logic [5:0]   rice_eff;

	logic         s1_valid_q;
	logic [7:0]   byte_s1;
	logic         first_s1;
	logic         last_s1;
	logic         adv;

	walk_state_t  walk_q;
	logic [63:0]  unary_q;
	logic [63:0]  sum_q;
	logic [31:0]  decoded_q;
	logic         decided_q;

	walk_state_t  walk_e;
	logic [63:0]  unary_e;
	logic [63:0]  sum_e;
	logic [31:0]  decoded_e;
	logic         decided_e;
	walk_result_t wres;

	logic [63:0]  unary_done;
	logic [63:0]  delta;
	logic [63:0]  sum_new;
	logic [31:0]  decoded_new;

	logic         emit;
	logic [1:0]   verdict_d;
	logic [31:0]  values_d;
	walk_state_t  walk_d;
	logic [63:0]  unary_d;
	logic [63:0]  sum_d;
	logic [31:0]  decoded_d;
	logic         decided_d;

	logic         m_valid_q;
	logic [1:0]   verdict_q;
	logic [31:0]  values_q;

	grsm_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	assign rice_eff = rice_clamp(cfg.rice_bits);

	assign adv      = s1_valid_q && (!m_valid_q || m_tready);
	assign s_tready = !s1_valid_q || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s_tready) begin
			s1_valid_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1  <= s_tdata;
			first_s1 <= s_tuser;
			last_s1  <= s_tlast;
		end
	end

	// a first byte sees the scan state as cleared
	always_comb begin
		if (first_s1) begin
			walk_e    = '0;
			unary_e   = '0;
			sum_e     = '0;
			decoded_e = '0;
			decided_e = 1'b0;
		end else begin
			walk_e    = walk_q;
			unary_e   = unary_q;
			sum_e     = sum_q;
			decoded_e = decoded_q;
			decided_e = decided_q;
		end
	end

	grsm_bit_walk u_walk (
		.byte_in  (byte_s1),
		.rice_eff (rice_eff),
		.st       (walk_e),
		.res      (wres)
	);

	assign unary_done  = unary_e + {60'd0, wres.ones_pre};
	assign delta       = (unary_done << rice_eff) | {32'd0, wres.acc_done};
	assign sum_new     = sum_e + delta;
	assign decoded_new = decoded_e + 32'd1;

	always_comb begin
		emit      = 1'b0;
		verdict_d = VERDICT_TRUNCATED;
		values_d  = decoded_e;
		walk_d    = wres.nxt;
		unary_d   = unary_done;
		sum_d     = sum_e;
		decoded_d = decoded_e;
		decided_d = decided_e;
		if (decided_e) begin
			walk_d  = walk_e;
			unary_d = unary_e;
		end else if (decoded_e >= cfg.element_count) begin
			emit      = 1'b1;
			verdict_d = VERDICT_EXHAUSTED;
			walk_d    = walk_e;
			unary_d   = unary_e;
			decided_d = 1'b1;
		end else begin
			if (wres.done) begin
				sum_d     = sum_new;
				decoded_d = decoded_new;
				unary_d   = {60'd0, wres.ones_post};
				values_d  = decoded_new;
			end
			if (wres.done && sum_new == cfg.target_hash) begin
				emit      = 1'b1;
				verdict_d = VERDICT_MATCH;
			end else if (wres.done && sum_new > cfg.target_hash) begin
				emit      = 1'b1;
				verdict_d = VERDICT_PASSED;
			end else if (wres.done && decoded_new >= cfg.element_count) begin
				emit      = 1'b1;
				verdict_d = VERDICT_EXHAUSTED;
			end else if (last_s1) begin
				emit      = 1'b1;
				verdict_d = VERDICT_TRUNCATED;
			end
			decided_d = emit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_q    <= '0;
			unary_q   <= '0;
			sum_q     <= '0;
			decoded_q <= '0;
			decided_q <= 1'b0;
		end else if (adv) begin
			walk_q    <= walk_d;
			unary_q   <= unary_d;
			sum_q     <= sum_d;
			decoded_q <= decoded_d;
			decided_q <= decided_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (adv) begin
			m_valid_q <= emit;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && emit) begin
			verdict_q <= verdict_d;
			values_q  <= values_d;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {6'd0, values_q, verdict_q};

endmodule
